@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the RTL of rgb_to_hsv_converter_unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/rgbhsv_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Types, constants, the divider step and the sector hue offsets of the RGB to HSV converter
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

    // one 60 degree sector and the full circle, 6 fractional bits
    localparam int HUE_SECTOR_FX = 3840;
    localparam int HUE_FULL_FX   = 23040;

    // pipeline layout
    localparam int PIPE_DEPTH     = 8;  // stages held in the pipeline array
    localparam int DIV_FIRST      = 2;  // first divider stage
    localparam int BITS_PER_STAGE = 2;  // quotient bits resolved per stage
    localparam int SAT_DIV_STAGES = 4;  // 8 saturation bits
    localparam int LAST_STAGE     = PIPE_DEPTH;  // output register index

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    // one pipeline stage; num_h and num_s hold remainder over quotient bits
    typedef struct packed {
        t_sector     sector;
        logic        neg;
        logic        grey;
        logic        black;
        logic [7:0]  vmax;
        logic [7:0]  chroma;
        logic [19:0] num_h;
        logic [15:0] num_s;
    } t_pipe;

    // restoring divider step: returns {new remainder, quotient bit}
    function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nbit,
                                            input logic [7:0] dvs);
        logic [8:0] t;
        logic [8:0] diff;
        t    = {rem, nbit};
        diff = t - {1'b0, dvs};
        if (t >= {1'b0, dvs}) begin
            div_step = {diff[7:0], 1'b1};
        end else begin
            div_step = {t[7:0], 1'b0};
        end
    endfunction

    // hue offset of a sector
    function automatic logic [14:0] hue_base(input t_sector sec);
        case (sec)
            SEC_RED:   hue_base = 15'd0;
            SEC_GREEN: hue_base = 15'(2 * HUE_SECTOR_FX);
            SEC_BLUE:  hue_base = 15'(4 * HUE_SECTOR_FX);
            default:   hue_base = 15'd0;
        endcase
    endfunction

endpackage

@@ hdl/rgb_to_hsv_converter_unit.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit
// Pipelined RGB to HSV pixel converter, when not stalled one pixel per clock
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------
//  pixel in | input     | i_valid / o_stall  | i_red, i_green, i_blue
//  hsv out  | output    | o_valid / i_stall  | o_hue, o_saturation, o_brightness
//
//  one pixel can be taken every clock while o_stall is low; the depth is set by
//  the 12-bit hue divider, which resolves two quotient bits per stage
//  i_rst_n is synchronous and clears only the stage valid bits
//  a stage moves when it is empty or the stage after it moves, so bubbles fill
//  o_stall is high only when every stage holds a pixel and i_stall is high
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_to_hsv_converter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [14:0] o_hue,
    output logic [7:0]  o_saturation,
    output logic [7:0]  o_brightness
);
    import rgbhsv_pkg::*;

    t_pipe              r_pipe [PIPE_DEPTH];
    t_pipe              n_pipe [PIPE_DEPTH];
    logic [LAST_STAGE:0] r_valid;
    logic [LAST_STAGE:0] stage_en;
    logic [14:0]        r_hue;
    logic [7:0]         r_sat;
    logic [7:0]         r_bright;
    logic [14:0]        n_hue;
    logic [7:0]         n_sat;

    // stage enables, rippling back from the output
    always_comb begin
        stage_en[LAST_STAGE] = !r_valid[LAST_STAGE] || !i_stall;
        for (int k = LAST_STAGE - 1; k >= 0; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k + 1];
        end
    end

    assign o_stall = !stage_en[0];

    // next value of every pipeline stage
    always_comb begin
        logic [7:0]  p;
        logic [7:0]  n;
        logic [7:0]  vmin;
        logic [19:0] a;
        logic [15:0] c;
        logic [8:0]  s;

        // stage 0: largest channel, sector and signed difference
        n_pipe[0] = '0;
        if (i_red >= i_green && i_red >= i_blue) begin
            n_pipe[0].sector = SEC_RED;
            n_pipe[0].vmax   = i_red;
            vmin = (i_green < i_blue) ? i_green : i_blue;
            p = i_green;
            n = i_blue;
        end else if (i_green >= i_blue) begin
            n_pipe[0].sector = SEC_GREEN;
            n_pipe[0].vmax   = i_green;
            vmin = (i_red < i_blue) ? i_red : i_blue;
            p = i_blue;
            n = i_red;
        end else begin
            n_pipe[0].sector = SEC_BLUE;
            n_pipe[0].vmax   = i_blue;
            vmin = (i_red < i_green) ? i_red : i_green;
            p = i_red;
            n = i_green;
        end
        n_pipe[0].chroma = n_pipe[0].vmax - vmin;
        n_pipe[0].neg    = (p < n);
        n_pipe[0].grey   = (n_pipe[0].vmax == vmin);
        n_pipe[0].black  = (n_pipe[0].vmax == 8'd0);
        n_pipe[0].num_h  = {12'd0, (p < n) ? (n - p) : (p - n)};

        // stage 1: dividends |d| * 3840 and chroma * 255 by shift and subtract
        a = {12'd0, r_pipe[0].num_h[7:0]};
        c = {8'd0, r_pipe[0].chroma};
        n_pipe[1]       = r_pipe[0];
        n_pipe[1].num_h = (a << 12) - (a << 8);
        n_pipe[1].num_s = (c << 8) - c;

        // divider stages: two hue bits each, two saturation bits in the first four
        for (int k = DIV_FIRST; k < PIPE_DEPTH; k++) begin
            n_pipe[k] = r_pipe[k - 1];
            for (int j = 0; j < BITS_PER_STAGE; j++) begin
                s = div_step(n_pipe[k].num_h[19:12], n_pipe[k].num_h[11],
                             n_pipe[k].chroma);
                n_pipe[k].num_h = {s[8:1], n_pipe[k].num_h[10:0], s[0]};
            end
            if (k - DIV_FIRST < SAT_DIV_STAGES) begin
                for (int j = 0; j < BITS_PER_STAGE; j++) begin
                    s = div_step(n_pipe[k].num_s[15:8], n_pipe[k].num_s[7],
                                 n_pipe[k].vmax);
                    n_pipe[k].num_s = {s[8:1], n_pipe[k].num_s[6:0], s[0]};
                end
            end
        end
    end

    // output stage: sector offset, sign, wrap and the grey and black cases
    always_comb begin
        logic [15:0] sum;
        logic [15:0] q;
        logic [15:0] base;
        q    = {4'd0, r_pipe[PIPE_DEPTH - 1].num_h[11:0]};
        base = {1'b0, hue_base(r_pipe[PIPE_DEPTH - 1].sector)};
        sum  = r_pipe[PIPE_DEPTH - 1].neg ? (base - q) : (base + q);
        if (r_pipe[PIPE_DEPTH - 1].grey) begin
            n_hue = 15'd0;
        end else if (sum[15]) begin
            n_hue = sum[14:0] + 15'(HUE_FULL_FX);
        end else begin
            n_hue = sum[14:0];
        end
        n_sat = r_pipe[PIPE_DEPTH - 1].black ? 8'd0 : r_pipe[PIPE_DEPTH - 1].num_s[7:0];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (stage_en[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k <= LAST_STAGE; k++) begin
                if (stage_en[k]) begin
                    r_valid[k] <= r_valid[k - 1];
                end
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PIPE_DEPTH; k++) begin
            if (stage_en[k]) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
        if (stage_en[LAST_STAGE]) begin
            r_hue    <= n_hue;
            r_sat    <= n_sat;
            r_bright <= r_pipe[PIPE_DEPTH - 1].vmax;
        end
    end

    assign o_valid      = r_valid[LAST_STAGE];
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_bright;

    // checks
    `ASSERT_IMPLIES(a_hue_range, i_clk, i_rst_n, o_valid, o_hue < 15'(HUE_FULL_FX),
                    "hue out of range")
    `ASSERT_IMPLIES(a_black_sat, i_clk, i_rst_n, o_valid && o_brightness == 8'd0,
                    o_saturation == 8'd0, "black pixel with nonzero saturation")
    `ASSERT_IMPLIES(a_grey_hue, i_clk, i_rst_n, o_valid && o_saturation == 8'd0,
                    o_hue == 15'd0, "zero saturation with nonzero hue")
    `ASSERT_IMPLIES(a_stall_full, i_clk, i_rst_n, o_stall, (&r_valid) && i_stall,
                    "input stalled while the pipeline has room")

endmodule
